// ===== hw/rtl/ufl_pkg.sv =====
// Shared widths, codes, reset values and interface types of the token limiter.
package ufl_pkg;

    // Token arithmetic width.
    localparam int TOKEN_W = 48;

    // Register field widths.
    localparam int UL_W  = 7;
    localparam int SM_W  = 9;
    localparam int TPS_W = 12;
    localparam int CF_W  = 7;

    // Beat field widths.
    localparam int KS_W         = 31;
    localparam int MU_W         = 10;
    localparam int ST_W         = 2;
    localparam int TOK_OUT_W    = 48;
    localparam int SHARE_OUT_W  = 47;
    localparam int CAP_OUT_W    = 47;

    // APB port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_UTIL_LIMIT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SM_COUNT       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THREADS_PER_SM = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CORE_FACTOR    = 3'd4;

    // Register reset values.
    localparam logic [UL_W-1:0]  UL_RESET  = 7'd50;
    localparam logic             EN_RESET  = 1'b1;
    localparam logic [SM_W-1:0]  SM_RESET  = 9'd1;
    localparam logic [TPS_W-1:0] TPS_RESET = 12'd1024;
    localparam logic [CF_W-1:0]  CF_RESET  = 7'd1;

    // Geometry products kept in registers.
    localparam int P_ST_W = SM_W + TPS_W;
    localparam int P_SC_W = SM_W + CF_W;
    localparam int P_TC_W = TPS_W + CF_W;
    localparam int GEO_W  = SM_W + TPS_W + CF_W;
    localparam int SST_W  = 2 * SM_W + TPS_W;
    localparam int GA_W   = TPS_W;
    localparam int GB_W   = P_ST_W;

    localparam logic [P_ST_W-1:0]  P_ST_RESET = SM_RESET * TPS_RESET;
    localparam logic [P_SC_W-1:0]  P_SC_RESET = SM_RESET * CF_RESET;
    localparam logic [P_TC_W-1:0]  P_TC_RESET = TPS_RESET * CF_RESET;
    localparam logic [SST_W-1:0]   SST_RESET  = SM_RESET * SM_RESET * TPS_RESET;
    localparam logic [TOKEN_W-1:0] CAP_RESET  = SM_RESET * TPS_RESET * CF_RESET;

    // Cycles the derived products need to follow a geometry write.
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = 2'd2;

    // Serial multiplier and divider.
    localparam int MUL_A_W     = SST_W;
    localparam int MUL_B_W     = MU_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W   = $clog2(MUL_B_W + 1);
    localparam int DIV_N_W     = PROD_W;
    localparam int DIV_D_W     = UL_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);

    // Increment scale: divide by 2560 as a right shift by 9 (divide by 512) and a divide by 5.
    localparam int UTIL_SCALE  = 2560;
    localparam int SCALE_DIV   = 5;
    localparam int SCALE_SHIFT = $clog2(UTIL_SCALE / SCALE_DIV);
    localparam int MIN_DIFF    = 5;
    localparam int LIMIT_OFF   = 100;

    // Wide arithmetic for share and token updates.
    localparam int EXT_W = ((TOKEN_W > PROD_W) ? TOKEN_W : PROD_W) + 2;

    localparam logic [TOKEN_W-1:0] TOK_MAX  = {1'b0, {(TOKEN_W-1){1'b1}}};
    localparam logic [TOKEN_W-1:0] TOK_HALF = TOK_MAX >> 1;

    // Commands and result status codes.
    localparam logic CMD_LAUNCH = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [ST_W-1:0] ST_GRANT  = 2'd0;
    localparam logic [ST_W-1:0] ST_WAIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BYPASS = 2'd2;
    localparam logic [ST_W-1:0] ST_TICK   = 2'd3;

    typedef struct packed {
        logic [UL_W-1:0]  util_limit;
        logic             enable;
        logic [SM_W-1:0]  sm_count;
        logic [TPS_W-1:0] threads_per_sm;
        logic [CF_W-1:0]  core_factor;
    } cfg_t;

    typedef struct packed {
        logic             fire;
        logic [GEO_W-1:0] cap;
    } reload_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/ufl_regs.sv =====
// APB register bank with geometry products and capacity reload events.
module ufl_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ufl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ufl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output ufl_pkg::cfg_t                      cfg,
    output logic [ufl_pkg::SST_W-1:0]          sst,
    output ufl_pkg::reload_t                   reload,
    output logic                               busy
);

    ufl_pkg::cfg_t                        cfg_reg;
    logic [ufl_pkg::P_ST_W-1:0]           p_st_reg;
    logic [ufl_pkg::P_SC_W-1:0]           p_sc_reg;
    logic [ufl_pkg::P_TC_W-1:0]           p_tc_reg;
    logic [ufl_pkg::SST_W-1:0]            sst_reg;
    logic [ufl_pkg::SETTLE_W-1:0]         settle_reg;

    logic                                 wr;
    logic                                 geo_wr;
    logic [ufl_pkg::REG_IDX_W-1:0]        idx;
    logic [ufl_pkg::GA_W-1:0]             geo_a;
    logic [ufl_pkg::GB_W-1:0]             geo_b;
    logic [ufl_pkg::GA_W+ufl_pkg::GB_W-1:0] geo_full;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ufl_pkg::APB_ADDR_W-1:2];
    assign geo_wr = wr && ((idx == ufl_pkg::REG_SM_COUNT) ||
                           (idx == ufl_pkg::REG_THREADS_PER_SM) ||
                           (idx == ufl_pkg::REG_CORE_FACTOR));

    // New capacity: written field times the product of the other two.
    always_comb
    begin
        unique case (idx)
            ufl_pkg::REG_SM_COUNT:
            begin
                geo_a = ufl_pkg::GA_W'(pwdata[ufl_pkg::SM_W-1:0]);
                geo_b = ufl_pkg::GB_W'(p_tc_reg);
            end
            ufl_pkg::REG_THREADS_PER_SM:
            begin
                geo_a = ufl_pkg::GA_W'(pwdata[ufl_pkg::TPS_W-1:0]);
                geo_b = ufl_pkg::GB_W'(p_sc_reg);
            end
            ufl_pkg::REG_CORE_FACTOR:
            begin
                geo_a = ufl_pkg::GA_W'(pwdata[ufl_pkg::CF_W-1:0]);
                geo_b = ufl_pkg::GB_W'(p_st_reg);
            end
            default:
            begin
                geo_a = '0;
                geo_b = '0;
            end
        endcase
    end

    assign geo_full   = geo_a * geo_b;
    assign reload.fire = geo_wr;
    assign reload.cap  = geo_full[ufl_pkg::GEO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.util_limit     <= ufl_pkg::UL_RESET;
            cfg_reg.enable         <= ufl_pkg::EN_RESET;
            cfg_reg.sm_count       <= ufl_pkg::SM_RESET;
            cfg_reg.threads_per_sm <= ufl_pkg::TPS_RESET;
            cfg_reg.core_factor    <= ufl_pkg::CF_RESET;
            p_st_reg               <= ufl_pkg::P_ST_RESET;
            p_sc_reg               <= ufl_pkg::P_SC_RESET;
            p_tc_reg               <= ufl_pkg::P_TC_RESET;
            sst_reg                <= ufl_pkg::SST_RESET;
            settle_reg             <= '0;
        end
        else
        begin
            if (wr)
            begin
                unique case (idx)
                    ufl_pkg::REG_UTIL_LIMIT:
                        cfg_reg.util_limit <= pwdata[ufl_pkg::UL_W-1:0];
                    ufl_pkg::REG_ENABLE:
                        cfg_reg.enable <= pwdata[0];
                    ufl_pkg::REG_SM_COUNT:
                        cfg_reg.sm_count <= pwdata[ufl_pkg::SM_W-1:0];
                    ufl_pkg::REG_THREADS_PER_SM:
                        cfg_reg.threads_per_sm <= pwdata[ufl_pkg::TPS_W-1:0];
                    ufl_pkg::REG_CORE_FACTOR:
                        cfg_reg.core_factor <= pwdata[ufl_pkg::CF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // Pairwise products are registered from the fields; sst from p_st_reg and sm_count.
            p_st_reg <= cfg_reg.sm_count * cfg_reg.threads_per_sm;
            p_sc_reg <= cfg_reg.sm_count * cfg_reg.core_factor;
            p_tc_reg <= cfg_reg.threads_per_sm * cfg_reg.core_factor;
            sst_reg  <= p_st_reg * cfg_reg.sm_count;
            if (geo_wr)
                settle_reg <= ufl_pkg::SETTLE_CYC;
            else if (settle_reg != '0)
                settle_reg <= settle_reg - 1'b1;
        end
    end

    always_comb
    begin
        unique case (idx)
            ufl_pkg::REG_UTIL_LIMIT:     prdata = ufl_pkg::APB_DATA_W'(cfg_reg.util_limit);
            ufl_pkg::REG_ENABLE:         prdata = ufl_pkg::APB_DATA_W'(cfg_reg.enable);
            ufl_pkg::REG_SM_COUNT:       prdata = ufl_pkg::APB_DATA_W'(cfg_reg.sm_count);
            ufl_pkg::REG_THREADS_PER_SM: prdata = ufl_pkg::APB_DATA_W'(cfg_reg.threads_per_sm);
            ufl_pkg::REG_CORE_FACTOR:    prdata = ufl_pkg::APB_DATA_W'(cfg_reg.core_factor);
            default:                     prdata = '0;
        endcase
    end

    assign cfg  = cfg_reg;
    assign sst  = sst_reg;
    assign busy = (settle_reg != '0);

endmodule

// ===== hw/rtl/ufl_mul.sv =====
// Shift-add multiplier that retires one multiplier bit per cycle.
module ufl_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  ufl_pkg::mul_req_t req,
    output ufl_pkg::mul_rsp_t rsp
);

    logic [ufl_pkg::PROD_W-1:0]    acc_reg;
    logic [ufl_pkg::PROD_W-1:0]    mcand_reg;
    logic [ufl_pkg::MUL_B_W-1:0]   mplier_reg;
    logic [ufl_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == ufl_pkg::MUL_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ufl_pkg::MUL_CNT_W'(ufl_pkg::MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ufl_pkg::MUL_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= ufl_pkg::PROD_W'(req.a);
            mplier_reg <= req.b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== hw/rtl/ufl_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module ufl_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ufl_pkg::div_req_t req,
    output ufl_pkg::div_rsp_t rsp
);

    logic [ufl_pkg::DIV_D_W-1:0]   rem_reg;
    logic [ufl_pkg::DIV_N_W-1:0]   quo_reg;
    logic [ufl_pkg::DIV_D_W-1:0]   dsr_reg;
    logic [ufl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [ufl_pkg::DIV_D_W:0]     trial;
    logic [ufl_pkg::DIV_D_W:0]     diff;
    logic                          fits;

    // Shift the next dividend bit into the partial remainder.
    assign trial = {rem_reg, quo_reg[ufl_pkg::DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == ufl_pkg::DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ufl_pkg::DIV_CNT_W'(ufl_pkg::DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ufl_pkg::DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[ufl_pkg::DIV_D_W-1:0] : trial[ufl_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[ufl_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/utilization_feedback_token_limiter.sv =====
// Top level: token bucket with utilization-driven refill and launch throttling.
//
// Beats enter on req_valid/req_stall and leave on rsp_valid/rsp_stall; a beat
// is taken at a clock edge where valid is high and stall is low. Every request
// beat yields exactly one response beat, in order.
// A launch request (cmd 0) is decided in the idle state and its result goes
// from the done state into the output register; no new request is taken until
// the core is back in idle. A tick (cmd 1) runs the increment through a shared
// bit-serial multiplier and a restoring divider, then, when the error is above
// half the limit, the boost multiply and divide by limit+1 as well, before the
// bucket-growth, share and token update steps.
// A stalled response sits in the output register; the core can still take and
// work a new request, but holds its result in the done state until it is taken.
// A write to sm_count, threads_per_sm or core_factor reloads the capacity at
// once, clamps share and tokens the cycle after, and holds off requests while
// the derived products settle. The user must make APB writes only while no
// request is in flight; the block does not enforce it. pready is always high.
// Reset clears tokens and share, loads capacity from the reset geometry and
// empties the output register.
module utilization_feedback_token_limiter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ufl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ufl_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ufl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 cmd,
    input  logic [ufl_pkg::KS_W-1:0]             kernel_size,
    input  logic [ufl_pkg::MU_W-1:0]             measured_util,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [ufl_pkg::ST_W-1:0]             status,
    output logic signed [ufl_pkg::TOK_OUT_W-1:0] tokens_now,
    output logic [ufl_pkg::SHARE_OUT_W-1:0]      share_now,
    output logic [ufl_pkg::CAP_OUT_W-1:0]        capacity_now
);

    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE = 4'd0;
    localparam logic [SW-1:0] S_MUL1 = 4'd1;
    localparam logic [SW-1:0] S_DIV1 = 4'd2;
    localparam logic [SW-1:0] S_MUL2 = 4'd3;
    localparam logic [SW-1:0] S_DIV2 = 4'd4;
    localparam logic [SW-1:0] S_DBL  = 4'd5;
    localparam logic [SW-1:0] S_SHR  = 4'd6;
    localparam logic [SW-1:0] S_TOK  = 4'd7;
    localparam logic [SW-1:0] S_DONE = 4'd8;

    ufl_pkg::cfg_t              cfg;
    ufl_pkg::reload_t           reload;
    logic [ufl_pkg::SST_W-1:0]  sst;
    logic                       cfg_busy;
    ufl_pkg::mul_req_t          mul_req;
    ufl_pkg::mul_rsp_t          mul_rsp;
    ufl_pkg::div_req_t          div_req;
    ufl_pkg::div_rsp_t          div_rsp;

    logic [SW-1:0]                         state_reg, state_next;
    logic signed [ufl_pkg::TOKEN_W-1:0]    tokens_reg, tokens_next;
    logic [ufl_pkg::TOKEN_W-1:0]           share_reg, share_next;
    logic [ufl_pkg::TOKEN_W-1:0]           capacity_reg, capacity_next;
    logic                                  clamp_pending_reg;
    logic [ufl_pkg::MU_W-1:0]              diff_reg, diff_next;
    logic                                  boost_reg, boost_next;
    logic                                  up_reg, up_next;
    logic [ufl_pkg::PROD_W-1:0]            inc_reg, inc_next;
    logic [ufl_pkg::ST_W-1:0]              status_reg, status_next;
    logic                                  rsp_valid_reg, rsp_valid_next;
    logic [ufl_pkg::ST_W-1:0]              rsp_status_reg, rsp_status_next;
    logic signed [ufl_pkg::TOK_OUT_W-1:0]  rsp_tokens_reg, rsp_tokens_next;
    logic [ufl_pkg::SHARE_OUT_W-1:0]       rsp_share_reg, rsp_share_next;
    logic [ufl_pkg::CAP_OUT_W-1:0]         rsp_cap_reg, rsp_cap_next;

    logic                                  accept;
    logic                                  bypass;
    logic [ufl_pkg::MU_W-1:0]              ul_ext;
    logic [ufl_pkg::MU_W-1:0]              diff_raw;
    logic [ufl_pkg::MU_W-1:0]              diff_in;
    logic [ufl_pkg::EXT_W-1:0]             share_ext;
    logic [ufl_pkg::EXT_W-1:0]             cap_ext;
    logic [ufl_pkg::EXT_W-1:0]             inc_ext;
    logic [ufl_pkg::EXT_W-1:0]             share_up;
    logic [ufl_pkg::EXT_W-1:0]             share_dn;
    logic signed [ufl_pkg::EXT_W-1:0]      tok_sx;
    logic signed [ufl_pkg::EXT_W-1:0]      cap_sx;
    logic signed [ufl_pkg::EXT_W-1:0]      tok_sum;
    logic [ufl_pkg::TOKEN_W-1:0]           cap_dbl;

    ufl_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .sst     (sst),
        .reload  (reload),
        .busy    (cfg_busy)
    );

    ufl_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ufl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req_stall = (state_reg != S_IDLE) || cfg_busy;
    assign accept    = req_valid && !req_stall;

    assign bypass = (cfg.util_limit == '0) ||
                    (cfg.util_limit >= ufl_pkg::UL_W'(ufl_pkg::LIMIT_OFF)) ||
                    !cfg.enable;

    // Utilization error, floored at the minimum step.
    assign ul_ext   = ufl_pkg::MU_W'(cfg.util_limit);
    assign diff_raw = (measured_util > ul_ext) ? (measured_util - ul_ext)
                                               : (ul_ext - measured_util);
    assign diff_in  = (diff_raw < ufl_pkg::MU_W'(ufl_pkg::MIN_DIFF))
                      ? ufl_pkg::MU_W'(ufl_pkg::MIN_DIFF) : diff_raw;

    assign share_ext = ufl_pkg::EXT_W'(share_reg);
    assign cap_ext   = ufl_pkg::EXT_W'(capacity_reg);
    assign inc_ext   = ufl_pkg::EXT_W'(inc_reg);
    assign share_up  = share_ext + inc_ext;
    assign share_dn  = share_ext - inc_ext;
    assign tok_sx    = ufl_pkg::EXT_W'(tokens_reg);
    assign cap_sx    = $signed(cap_ext);
    assign tok_sum   = tok_sx + $signed(share_ext);
    assign cap_dbl   = (capacity_reg > ufl_pkg::TOK_HALF) ? ufl_pkg::TOK_MAX
                                                          : (capacity_reg << 1);

    always_comb
    begin
        state_next      = state_reg;
        tokens_next     = tokens_reg;
        share_next      = share_reg;
        capacity_next   = capacity_reg;
        diff_next       = diff_reg;
        boost_next      = boost_reg;
        up_next         = up_reg;
        inc_next        = inc_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_tokens_next = rsp_tokens_reg;
        rsp_share_next  = rsp_share_reg;
        rsp_cap_next    = rsp_cap_reg;
        mul_req         = '0;
        div_req         = '0;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        if (reload.fire)
            capacity_next = ufl_pkg::TOKEN_W'(reload.cap);

        // Pull share and tokens under a freshly reloaded capacity.
        if (clamp_pending_reg)
        begin
            if (share_reg > capacity_reg)
                share_next = capacity_reg;
            if (tok_sx > cap_sx)
                tokens_next = capacity_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == ufl_pkg::CMD_LAUNCH)
                    begin
                        if (bypass)
                            status_next = ufl_pkg::ST_BYPASS;
                        else if (tokens_reg[ufl_pkg::TOKEN_W-1])
                            status_next = ufl_pkg::ST_WAIT;
                        else
                        begin
                            tokens_next = tokens_reg - ufl_pkg::TOKEN_W'(kernel_size);
                            status_next = ufl_pkg::ST_GRANT;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        diff_next   = diff_in;
                        boost_next  = diff_in > ufl_pkg::MU_W'(cfg.util_limit >> 1);
                        up_next     = measured_util <= ul_ext;
                        status_next = ufl_pkg::ST_TICK;
                        mul_req.start = 1'b1;
                        mul_req.a     = sst;
                        mul_req.b     = ufl_pkg::MUL_B_W'(diff_in);
                        state_next    = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                if (mul_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.prod >> ufl_pkg::SCALE_SHIFT;
                    div_req.divisor  = ufl_pkg::DIV_D_W'(ufl_pkg::SCALE_DIV);
                    state_next       = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (boost_reg)
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = div_rsp.quotient[ufl_pkg::MUL_A_W-1:0];
                        mul_req.b     = {diff_reg, 1'b0};
                        state_next    = S_MUL2;
                    end
                    else
                    begin
                        inc_next   = div_rsp.quotient;
                        state_next = S_DBL;
                    end
                end
            end
            S_MUL2:
            begin
                if (mul_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.prod;
                    div_req.divisor  = ufl_pkg::DIV_D_W'(cfg.util_limit) +
                                       ufl_pkg::DIV_D_W'(1);
                    state_next       = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    inc_next   = div_rsp.quotient;
                    state_next = S_DBL;
                end
            end
            S_DBL:
            begin
                // Full share with a token debt: grow the bucket.
                if ((share_reg == capacity_reg) && tokens_reg[ufl_pkg::TOKEN_W-1])
                begin
                    capacity_next = cap_dbl;
                    share_next    = cap_dbl;
                end
                state_next = S_SHR;
            end
            S_SHR:
            begin
                if (up_reg)
                    share_next = (share_up > cap_ext) ? capacity_reg
                                                      : share_up[ufl_pkg::TOKEN_W-1:0];
                else
                    share_next = (inc_ext > share_ext) ? '0
                                                       : share_dn[ufl_pkg::TOKEN_W-1:0];
                state_next = S_TOK;
            end
            S_TOK:
            begin
                tokens_next = (tok_sum > cap_sx) ? capacity_reg
                                                 : tok_sum[ufl_pkg::TOKEN_W-1:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free or drains this cycle.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_tokens_next = ufl_pkg::TOK_OUT_W'(tokens_reg);
                    rsp_share_next  = ufl_pkg::SHARE_OUT_W'(share_reg);
                    rsp_cap_next    = ufl_pkg::CAP_OUT_W'(capacity_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            tokens_reg        <= '0;
            share_reg         <= '0;
            capacity_reg      <= ufl_pkg::CAP_RESET;
            clamp_pending_reg <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tokens_reg        <= tokens_next;
            share_reg         <= share_next;
            capacity_reg      <= capacity_next;
            clamp_pending_reg <= reload.fire;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        boost_reg      <= boost_next;
        up_reg         <= up_next;
        inc_reg        <= inc_next;
        status_reg     <= status_next;
        rsp_status_reg <= rsp_status_next;
        rsp_tokens_reg <= rsp_tokens_next;
        rsp_share_reg  <= rsp_share_next;
        rsp_cap_reg    <= rsp_cap_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign tokens_now   = rsp_tokens_reg;
    assign share_now    = rsp_share_reg;
    assign capacity_now = rsp_cap_reg;

    a_share_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !clamp_pending_reg) |-> (share_reg <= capacity_reg))
        else $error("share above capacity while idle");

    a_tokens_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !clamp_pending_reg)
            |-> (tokens_reg[ufl_pkg::TOKEN_W-1] || (tokens_reg <= capacity_reg)))
        else $error("tokens above capacity while idle");

    a_capacity_max: assert property (@(posedge clk) disable iff (!rst_n)
        capacity_reg <= ufl_pkg::TOK_MAX)
        else $error("capacity beyond signed token range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start work");

    a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier finished outside a multiply step");

endmodule

// ===== bench/utilization_feedback_token_limiter_tb.sv =====
// Self-checking bench for the utilization feedback token limiter.
module utilization_feedback_token_limiter_tb;

    import ufl_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic            cmd;
        logic [KS_W-1:0] kernel_size;
        logic [MU_W-1:0] util;
    } throttle_req_t;

    typedef struct {
        logic [ST_W-1:0]        status;
        logic [TOK_OUT_W-1:0]   tokens;
        logic [SHARE_OUT_W-1:0] share;
        logic [CAP_OUT_W-1:0]   capacity;
    } throttle_rsp_t;

    // Index that decodes to no register.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd6;

    localparam int HALF_PERIOD = 4;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]         paddr = '0;
    logic [APB_DATA_W-1:0]         pwdata = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic                          cmd = CMD_LAUNCH;
    logic [KS_W-1:0]               kernel_size = '0;
    logic [MU_W-1:0]               measured_util = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic [ST_W-1:0]               status;
    logic signed [TOK_OUT_W-1:0]   tokens_now;
    logic [SHARE_OUT_W-1:0]        share_now;
    logic [CAP_OUT_W-1:0]          capacity_now;

    // Predicted block state and register copy.
    cfg_t                          cfg;
    logic signed [TOKEN_W-1:0]     tok_q;
    logic [TOKEN_W-1:0]            share_q;
    logic [TOKEN_W-1:0]            cap_q;

    throttle_req_t                 pending_reqs[$];
    throttle_rsp_t                 expected_rsps[$];
    throttle_req_t                 next_req;
    throttle_rsp_t                 want;
    logic                          req_taken = 1'b0;
    logic                          drain_hold = 1'b0;
    int                            send_idle_pct = 14;
    int                            recv_idle_pct = 45;
    int                            errors = 0;

    utilization_feedback_token_limiter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .kernel_size   (kernel_size),
        .measured_util (measured_util),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .tokens_now    (tokens_now),
        .share_now     (share_now),
        .capacity_now  (capacity_now)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (errors < 100)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic u64_t geometry_capacity();
        u64_t p;
        p = u64_t'(cfg.sm_count) * u64_t'(cfg.threads_per_sm) * u64_t'(cfg.core_factor);
        if (p > u64_t'(TOK_MAX))
            p = u64_t'(TOK_MAX);
        return p;
    endfunction

    function automatic u64_t adjusted_share(input u64_t util, input u64_t cur, input u64_t c);
        u64_t lim;
        u64_t diff;
        u64_t inc;
        lim = u64_t'(cfg.util_limit);
        diff = (lim > util) ? lim - util : util - lim;
        if (diff < MIN_DIFF)
            diff = MIN_DIFF;
        inc = u64_t'(cfg.sm_count) * u64_t'(cfg.sm_count) * u64_t'(cfg.threads_per_sm)
              * diff / UTIL_SCALE;
        // boost when far off target
        if (diff > lim / 2)
            inc = inc * diff * 2 / (lim + 1);
        if (util <= lim)
            return (inc > c - cur) ? c : cur + inc;
        return (inc > cur) ? 0 : cur - inc;
    endfunction

    function automatic throttle_rsp_t predict_throttle(input throttle_req_t r);
        throttle_rsp_t o;
        longint t;
        u64_t c;
        u64_t s;
        u64_t tmax;
        t = longint'(tok_q);
        c = u64_t'(cap_q);
        s = u64_t'(share_q);
        tmax = u64_t'(TOK_MAX);
        if (r.cmd == CMD_LAUNCH) begin
            if (cfg.util_limit == 0 || cfg.util_limit >= LIMIT_OFF || !cfg.enable)
                o.status = ST_BYPASS;
            else if (t < 0)
                o.status = ST_WAIT;
            else begin
                t = t - longint'(u64_t'(r.kernel_size));
                o.status = ST_GRANT;
            end
        end
        else begin
            // starved at full share: grow the bucket
            if (s == c && t < 0) begin
                c = (c > tmax / 2) ? tmax : c * 2;
                s = c;
            end
            s = adjusted_share(u64_t'(r.util), s, c);
            if (t >= 0 && u64_t'(t) > c - s)
                t = longint'(c);
            else begin
                t = t + longint'(s);
                if (t > longint'(c))
                    t = longint'(c);
            end
            o.status = ST_TICK;
        end
        tok_q = t[TOKEN_W-1:0];
        cap_q = c[TOKEN_W-1:0];
        share_q = s[TOKEN_W-1:0];
        o.tokens = t[TOK_OUT_W-1:0];
        o.share = s[SHARE_OUT_W-1:0];
        o.capacity = c[CAP_OUT_W-1:0];
        return o;
    endfunction

    function automatic void queue_launch(input logic [KS_W-1:0] ks);
        throttle_req_t r;
        r.cmd = CMD_LAUNCH;
        r.kernel_size = ks;
        r.util = MU_W'($urandom);
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_tick(input logic [MU_W-1:0] mu);
        throttle_req_t r;
        r.cmd = CMD_TICK;
        r.kernel_size = KS_W'($urandom);
        r.util = mu;
        pending_reqs.push_back(r);
    endfunction

    // Write a register over APB, track it, and read it back if the index decodes.
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
        logic [APB_DATA_W-1:0] raw;
        logic [APB_DATA_W-1:0] expect_rd;
        logic [APB_DATA_W-1:0] got;
        raw = val;
        // junk above every field width must be dropped
        if ($urandom_range(1) == 1)
            raw[APB_DATA_W-1:TPS_W] = $urandom;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= raw;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_UTIL_LIMIT:     cfg.util_limit = raw[UL_W-1:0];
            REG_ENABLE:         cfg.enable = raw[0];
            REG_SM_COUNT:       cfg.sm_count = raw[SM_W-1:0];
            REG_THREADS_PER_SM: cfg.threads_per_sm = raw[TPS_W-1:0];
            REG_CORE_FACTOR:    cfg.core_factor = raw[CF_W-1:0];
            default: ;
        endcase
        if (idx == REG_SM_COUNT || idx == REG_THREADS_PER_SM || idx == REG_CORE_FACTOR) begin
            cap_q = geometry_capacity();
            if (share_q > cap_q)
                share_q = cap_q;
            if (longint'(tok_q) > longint'(cap_q))
                tok_q = cap_q;
        end
        case (idx)
            REG_UTIL_LIMIT:     expect_rd = APB_DATA_W'(cfg.util_limit);
            REG_ENABLE:         expect_rd = APB_DATA_W'(cfg.enable);
            REG_SM_COUNT:       expect_rd = APB_DATA_W'(cfg.sm_count);
            REG_THREADS_PER_SM: expect_rd = APB_DATA_W'(cfg.threads_per_sm);
            REG_CORE_FACTOR:    expect_rd = APB_DATA_W'(cfg.core_factor);
            default: return;
        endcase
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== expect_rd)
            flag_mismatch($sformatf("register %0d read %0h, expected %0h", idx, got, expect_rd));
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    endtask

    task automatic configure_phase(input int ph);
        int unsigned ul;
        int unsigned en;
        int unsigned sm;
        int unsigned tp;
        int unsigned cf;
        ul = $urandom_range(99, 1);
        en = 1;
        sm = $urandom_range(48, 1);
        tp = $urandom_range(2048, 1);
        cf = $urandom_range(8, 1);
        case (ph)
            1: begin ul = 1; sm = 2; tp = 4095; cf = 127; end
            2: begin ul = 99; sm = 511; tp = 4095; cf = 127; end
            3: en = 0;
            4: ul = 127;
            5: begin tp = 0; cf = 0; end
            default: ;
        endcase
        set_reg(REG_UTIL_LIMIT, ul);
        set_reg(REG_ENABLE, en);
        set_reg(REG_SM_COUNT, sm);
        set_reg(REG_THREADS_PER_SM, tp);
        set_reg(REG_CORE_FACTOR, cf);
    endtask

    task automatic queue_random(input int n);
        logic [KS_W-1:0] ks;
        logic [31:0] span;
        int m;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 45) begin
                case ($urandom_range(6))
                    0: m = 0;
                    1: m = 1023;
                    2: m = $urandom_range(1023);
                    3, 4: m = int'(cfg.util_limit) + $urandom_range(12) - 6;
                    default: m = $urandom_range(120);
                endcase
                if (m < 0)
                    m = 0;
                queue_tick(MU_W'(m));
            end
            else begin
                span = (cap_q > 48'h3FFF_FFFF) ? 32'h7FFF_FFFF : 32'(cap_q * 2);
                case ($urandom_range(7))
                    0: ks = '0;
                    1: ks = '1;
                    2, 3: ks = KS_W'($urandom);
                    4, 5: ks = KS_W'($urandom_range(4096));
                    default: ks = KS_W'($urandom_range(span, 0));
                endcase
                queue_launch(ks);
            end
        end
    endtask

    // Request driver: hold a stalled beat, otherwise idle or present the next one.
    always @(negedge clk) begin
        rsp_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
        if (rst_n && (!req_valid || req_taken)) begin
            if (drain_hold && expected_rsps.size() == 0)
                drain_hold = 1'b0;
            if (drain_hold || pending_reqs.size() == 0 || $urandom_range(99) < send_idle_pct)
                req_valid <= 1'b0;
            else if ($urandom_range(29) == 0 && expected_rsps.size() != 0) begin
                // pause until every outstanding beat is answered
                drain_hold = 1'b1;
                req_valid <= 1'b0;
            end
            else begin
                next_req = pending_reqs.pop_front();
                req_valid <= 1'b1;
                cmd <= next_req.cmd;
                kernel_size <= next_req.kernel_size;
                measured_util <= next_req.util;
            end
        end
    end

    // Predict on each accepted request beat, check each accepted response beat.
    always @(posedge clk) begin
        req_taken <= req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            expected_rsps.push_back(predict_throttle(throttle_req_t'{cmd, kernel_size,
                                                                     measured_util}));
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0)
                flag_mismatch("response beat with nothing outstanding");
            else begin
                want = expected_rsps.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (tokens_now !== want.tokens)
                    flag_mismatch($sformatf("tokens_now %0d, expected %0d",
                                            tokens_now, $signed(want.tokens)));
                if (share_now !== want.share)
                    flag_mismatch($sformatf("share_now %0d, expected %0d",
                                            share_now, want.share));
                if (capacity_now !== want.capacity)
                    flag_mismatch($sformatf("capacity_now %0d, expected %0d",
                                            capacity_now, want.capacity));
            end
        end
    end

    initial begin
        cfg.util_limit = UL_RESET;
        cfg.enable = EN_RESET;
        cfg.sm_count = SM_RESET;
        cfg.threads_per_sm = TPS_RESET;
        cfg.core_factor = CF_RESET;
        tok_q = '0;
        share_q = '0;
        cap_q = geometry_capacity();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: grant, wait, both tick directions, minimum error.
        queue_launch('0);
        queue_tick('0);
        queue_launch('1);
        queue_launch(31'd5);
        queue_tick('1);
        queue_tick(10'd50);
        queue_tick(10'd48);
        queue_tick('0);
        queue_launch(31'd1);
        wait_idle();

        // Fill the bucket, then shrink it under full share and tokens.
        set_reg(REG_SM_COUNT, 64);
        queue_tick('0);
        wait_idle();
        set_reg(REG_THREADS_PER_SM, 512);
        // Starve at full share so the capacity doubles.
        queue_launch('1);
        queue_tick('0);
        queue_tick('0);
        queue_launch(31'd1);
        queue_tick('1);
        wait_idle();

        // Throttling off: disabled, zero limit, limit at and above 100.
        set_reg(REG_SM_COUNT, 1);
        set_reg(REG_THREADS_PER_SM, 1024);
        set_reg(REG_ENABLE, 0);
        set_reg(REG_UNUSED, 32'h0000_0FFF);
        queue_launch(31'd100);
        queue_tick(10'd10);
        wait_idle();
        set_reg(REG_ENABLE, 1);
        set_reg(REG_UTIL_LIMIT, 0);
        queue_launch(31'd7);
        queue_tick('0);
        queue_tick('1);
        wait_idle();
        set_reg(REG_UTIL_LIMIT, 100);
        queue_launch(31'd3);
        wait_idle();
        set_reg(REG_UTIL_LIMIT, 127);
        queue_tick('1);
        queue_launch('0);
        wait_idle();

        // Zero geometry.
        set_reg(REG_UTIL_LIMIT, 50);
        set_reg(REG_SM_COUNT, 0);
        queue_tick('0);
        queue_launch(31'd9);
        queue_tick('0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 45;
            end
            else if (ph < 6) begin
                send_idle_pct = 45;
                recv_idle_pct = 14;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure_phase(ph);
            queue_random(62);
            wait_idle();
        end

        repeat (150) @(posedge clk);
        if (expected_rsps.size() != 0)
            flag_mismatch("responses still outstanding at end of run");
        if (errors == 0)
            $display("utilization_feedback_token_limiter regression: pass");
        else
            $display("utilization_feedback_token_limiter regression: fail");
        $finish;
    end

    initial begin
        #(2 * HALF_PERIOD * 600_000);
        $display("utilization_feedback_token_limiter regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ufl_pkg.sv
hw/rtl/ufl_regs.sv
hw/rtl/ufl_mul.sv
hw/rtl/ufl_div.sv
hw/rtl/utilization_feedback_token_limiter.sv
bench/utilization_feedback_token_limiter_tb.sv
